// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Operation and status codes and the fixed widths of handles and generations.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

  localparam int unsigned GEN_BITS    = 32;
  localparam int unsigned HANDLE_BITS = 64;

  typedef logic [GEN_BITS-1:0] gen_t;

  typedef enum logic [1:0] {
    ACT_CREATE  = 2'd0,
    ACT_DESTROY = 2'd1,
    ACT_QUERY   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== design/gha_free_stack.sv =====
// ----------------------------------------------------------------------------
// Free-index stack
// Stack memory of free slots with their generations, a registered read of the
// top of stack with write bypass, and a high-water mark that stands in for the
// reset contents of positions never yet written.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_free_stack #(
  parameter int unsigned SLOT_COUNT = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [$clog2(SLOT_COUNT)-1:0]        rd_addr,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(SLOT_COUNT)-1:0]        wr_addr,
  input  wire logic [$clog2(SLOT_COUNT)-1:0]        wr_slot,
  input  wire gha_pkg::gen_t                        wr_gen,
  output logic      [$clog2(SLOT_COUNT)-1:0]        top_slot,
  output gha_pkg::gen_t                             top_gen,
  output logic      [$clog2(SLOT_COUNT)-1:0]        mark
);

  localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
  localparam int unsigned ENTRY_W = IDX_W + gha_pkg::GEN_BITS;

  logic [ENTRY_W-1:0] mem [SLOT_COUNT];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr_q;
  logic               written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_slot, wr_gen};
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= {wr_slot, wr_gen};
    end else begin
      rd_data <= mem[rd_addr];
    end
    rd_addr_q <= rd_addr;
  end

  // Highest stack position ever reached. A position below it has been pushed
  // to since it was last popped; at or above it the reset contents still hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= '0;
    end else if (rd_addr > mark) begin
      mark <= rd_addr;
    end
  end

  assign written  = (rd_addr_q < mark);
  assign top_slot = written ? rd_data[ENTRY_W-1:gha_pkg::GEN_BITS] : rd_addr_q + 1'b1;
  assign top_gen  = written ? rd_data[gha_pkg::GEN_BITS-1:0] : '0;

endmodule

`default_nettype wire

// ===== design/gha_slot_table.sv =====
// ----------------------------------------------------------------------------
// Slot table
// Per-slot live bit, generation and kind in one memory, with a registered read,
// write bypass, and slots beyond the high-water mark reading as never created.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_slot_table #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned KIND_BITS  = 8
) (
  input  wire logic                          clk,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] mark,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  wire logic [KIND_BITS-1:0]          wr_kind,
  input  wire gha_pkg::gen_t                 wr_gen,
  input  wire logic                          wr_live,
  output logic      [KIND_BITS-1:0]          rd_kind,
  output gha_pkg::gen_t                      rd_gen,
  output logic                               rd_live
);

  localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
  localparam int unsigned ENTRY_W = KIND_BITS + gha_pkg::GEN_BITS + 1;

  logic [ENTRY_W-1:0] mem [SLOT_COUNT];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr_q;
  logic               created;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_kind, wr_gen, wr_live};
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= {wr_kind, wr_gen, wr_live};
    end else begin
      rd_data <= mem[rd_addr];
    end
    rd_addr_q <= rd_addr;
  end

  // Slot s is first handed out when the stack reaches position s-1, so every
  // slot ever written lies at or below the stack's high-water mark.
  assign created = (rd_addr_q <= mark);
  assign rd_live = created & rd_data[0];
  assign rd_gen  = created ? rd_data[gha_pkg::GEN_BITS:1] : '0;
  assign rd_kind = rd_data[ENTRY_W-1:gha_pkg::GEN_BITS+1];

endmodule

`default_nettype wire

// ===== design/generational_handle_allocator.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator
// Issues, retires and checks 64-bit slot handles (index over generation) from
// a free-index stack and a per-slot table of live bit, generation and kind.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Words carried
//   request   req_valid/req_ready   action, handle, kind
//   response  rsp_valid/rsp_ready   status, new_handle, is_valid, stored_kind,
//                                   kind_match
//
// One request is accepted per cycle while the response side does not stall.
// The accepting clock edge registers the request into the operation stage,
// and the stack top and the addressed slot from their memories; the
// operation stage then decides and, once the response register is free or
// being emptied, writes both memories back and loads the response register,
// which sets rsp_valid. Back-to-back hazards are covered by write bypass
// on both memories.
// Reset is synchronous and clears only control state; no clearing pass runs,
// as a high-water mark of the stack marks which entries hold written data.
// A stalled response holds the operation stage, which holds the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned KIND_BITS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_ready,
  input  wire logic [1:0]                        action,
  input  wire logic [gha_pkg::HANDLE_BITS-1:0]   handle,
  input  wire logic [KIND_BITS-1:0]              kind,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_ready,
  output logic [1:0]                             status,
  output logic [gha_pkg::HANDLE_BITS-1:0]        new_handle,
  output logic                                   is_valid,
  output logic [KIND_BITS-1:0]                   stored_kind,
  output logic                                   kind_match
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned GEN_W = gha_pkg::GEN_BITS;
  localparam logic [IDX_W-1:0] CURSOR_FULL = IDX_W'(SLOT_COUNT - 1);
  localparam logic [GEN_W-1:0] SLOT_LIMIT  = GEN_W'(SLOT_COUNT);

  // Operation stage: the accepted request, waiting on its memory reads.
  logic                            op_valid;
  logic [1:0]                      op_action;
  logic [gha_pkg::HANDLE_BITS-1:0] op_handle;
  logic [KIND_BITS-1:0]            op_kind;

  logic advance;
  logic execute;
  logic take;

  // Stack state: cursor counts the slots currently handed out.
  logic [IDX_W-1:0] cursor;
  logic [IDX_W-1:0] cursor_next;
  logic [IDX_W-1:0] cursor_calc;
  logic [IDX_W-1:0] mark;
  logic [IDX_W-1:0] top_slot;
  gha_pkg::gen_t    top_gen;
  gha_pkg::gen_t    top_gen_inc;

  // Addressed slot as read from the table.
  logic [IDX_W-1:0]     slot_raddr;
  logic [KIND_BITS-1:0] slot_kind;
  gha_pkg::gen_t        slot_gen;
  logic                 slot_live;

  // Decoded handle of the operation stage.
  logic [GEN_W-1:0] op_index;
  gha_pkg::gen_t    op_gen;
  logic [IDX_W-1:0] op_slot;
  logic             handle_good;

  // Memory write requests before gating by execute.
  logic                 stack_we;
  logic                 stack_wr_en;
  logic                 slot_we;
  logic                 slot_wr_en;
  logic [IDX_W-1:0]     slot_waddr;
  logic [KIND_BITS-1:0] slot_wkind;
  gha_pkg::gen_t        slot_wgen;
  logic                 slot_wlive;

  // Response computed in the operation stage.
  gha_pkg::status_t                res_status;
  logic [gha_pkg::HANDLE_BITS-1:0] res_new_handle;
  logic                            res_valid;
  logic [KIND_BITS-1:0]            res_kind;
  logic                            res_match;

  // The response register parts the two sides: the operation stage moves on
  // whenever the response register is empty or being emptied.
  assign advance   = !rsp_valid || rsp_ready;
  assign execute   = op_valid && advance;
  assign req_ready = !op_valid || advance;
  assign take      = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (req_ready) begin
      op_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_action <= action;
      op_handle <= handle;
      op_kind   <= kind;
    end
  end

  // The slot read follows the incoming request, or re-reads the held one so
  // that a stalled operation always sees the table as it stands.
  assign slot_raddr = take ? handle[GEN_W +: IDX_W] : op_handle[GEN_W +: IDX_W];

  assign op_index    = op_handle[gha_pkg::HANDLE_BITS-1:GEN_W];
  assign op_gen      = op_handle[GEN_W-1:0];
  assign op_slot     = op_index[IDX_W-1:0];
  assign top_gen_inc = top_gen + 1'b1;

  // A handle is good when it names an issuable slot that is live and whose
  // generation is the current one. Slot zero is never issued.
  assign handle_good = (op_index != '0) && (op_index < SLOT_LIMIT) &&
                       slot_live && (slot_gen == op_gen);

  always_comb begin
    res_status     = gha_pkg::ST_STALE;
    res_new_handle = '0;
    res_valid      = 1'b0;
    res_kind       = '0;
    res_match      = 1'b0;
    cursor_calc    = cursor;
    stack_we       = 1'b0;
    slot_we        = 1'b0;
    slot_waddr     = top_slot;
    slot_wkind     = op_kind;
    slot_wgen      = top_gen_inc;
    slot_wlive     = 1'b1;
    case (op_action)
      gha_pkg::ACT_CREATE: begin
        if (cursor == CURSOR_FULL) begin
          res_status = gha_pkg::ST_FULL;
        end else begin
          res_status     = gha_pkg::ST_OK;
          res_new_handle = {{(GEN_W-IDX_W){1'b0}}, top_slot, top_gen_inc};
          cursor_calc    = cursor + 1'b1;
          slot_we        = 1'b1;
        end
      end
      gha_pkg::ACT_DESTROY: begin
        if (handle_good && (cursor != '0)) begin
          res_status  = gha_pkg::ST_OK;
          cursor_calc = cursor - 1'b1;
          stack_we    = 1'b1;
          slot_we     = 1'b1;
          slot_waddr  = op_slot;
          slot_wkind  = slot_kind;
          slot_wgen   = op_gen;
          slot_wlive  = 1'b0;
        end
      end
      gha_pkg::ACT_QUERY: begin
        if (handle_good) begin
          res_status = gha_pkg::ST_OK;
          res_valid  = 1'b1;
          res_kind   = slot_kind;
          res_match  = (slot_kind == op_kind);
        end
      end
      default: begin
        res_status = gha_pkg::ST_STALE;
      end
    endcase
  end

  assign cursor_next = execute ? cursor_calc : cursor;
  assign stack_wr_en = stack_we && execute && !rst;
  assign slot_wr_en  = slot_we && execute && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else begin
      cursor <= cursor_next;
    end
  end

  // The stack is read at the cursor the next operation will see, so a pop
  // always finds its top already registered.
  gha_free_stack #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (cursor_next),
    .wr_en    (stack_wr_en),
    .wr_addr  (cursor_calc),
    .wr_slot  (op_slot),
    .wr_gen   (op_gen),
    .top_slot (top_slot),
    .top_gen  (top_gen),
    .mark     (mark)
  );

  gha_slot_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .KIND_BITS  (KIND_BITS)
  ) u_slots (
    .clk     (clk),
    .rd_addr (slot_raddr),
    .mark    (mark),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_waddr),
    .wr_kind (slot_wkind),
    .wr_gen  (slot_wgen),
    .wr_live (slot_wlive),
    .rd_kind (slot_kind),
    .rd_gen  (slot_gen),
    .rd_live (slot_live)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (execute) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (execute) begin
      status      <= res_status;
      new_handle  <= res_new_handle;
      is_valid    <= res_valid;
      stored_kind <= res_kind;
      kind_match  <= res_match;
    end
  end

endmodule

`default_nettype wire

// ===== design/gha_checker.sv =====
// ----------------------------------------------------------------------------
// Generational handle allocator checker
// Port-level properties of the allocator's responses, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gha_checker #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned KIND_BITS  = 8
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic [1:0]                      action,
  input wire logic [gha_pkg::HANDLE_BITS-1:0] handle,
  input wire logic [KIND_BITS-1:0]            kind,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [1:0]                      status,
  input wire logic [gha_pkg::HANDLE_BITS-1:0] new_handle,
  input wire logic                            is_valid,
  input wire logic [KIND_BITS-1:0]            stored_kind,
  input wire logic                            kind_match
);

  logic                                       rsp_ok;
  logic                                       index_ok;
  logic                                       kind_seen;
  logic                                       query_ok;
  logic [gha_pkg::GEN_BITS-1:0]               issued_index;
  logic [gha_pkg::HANDLE_BITS+KIND_BITS+1:0]  req_word;
  logic [gha_pkg::HANDLE_BITS+KIND_BITS+3:0]  rsp_word;

  assign rsp_ok       = (status == gha_pkg::ST_OK);
  assign issued_index = new_handle[gha_pkg::HANDLE_BITS-1:gha_pkg::GEN_BITS];
  assign index_ok     = (issued_index != '0) && (issued_index < SLOT_COUNT);
  assign kind_seen    = kind_match || (stored_kind != '0);
  assign query_ok     = is_valid && rsp_ok && (new_handle == '0);
  assign req_word     = {action, handle, kind};
  assign rsp_word     = {status, new_handle, is_valid, stored_kind, kind_match};

  // A waiting request keeps its word.
  `ASSERT_NEXT(a_req_hold, clk, rst, req_valid && !req_ready, req_valid && $stable(req_word))

  // A held response keeps its word.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

  // Only a successful reply carries a handle.
  `ASSERT_SAME(a_handle_only_ok, clk, rst, rsp_valid && !rsp_ok, new_handle == '0)

  // An issued handle never names slot zero or a slot beyond the table.
  `ASSERT_SAME(a_handle_range, clk, rst, rsp_valid && (new_handle != '0), index_ok)

  // Kind results appear only with a valid query.
  `ASSERT_SAME(a_kind_needs_valid, clk, rst, rsp_valid && kind_seen, query_ok)

endmodule

bind generational_handle_allocator gha_checker #(
  .SLOT_COUNT (SLOT_COUNT),
  .KIND_BITS  (KIND_BITS)
) u_gha_checker (.*);

`default_nettype wire

// ===== sim/gha_ledger_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot ledger for the handle allocator bench
// Keeps a copy of the free-index stack and the slot table, predicts the reply
// to each accepted request and compares the replies of the block with it.
// ----------------------------------------------------------------------------
package gha_ledger_pkg;

  import gha_pkg::*;

  localparam int SLOTS  = 256;
  localparam int KIND_W = 8;
  localparam int IDX_W  = $clog2(SLOTS);

  typedef struct {
    status_t             status;
    logic [63:0]         new_handle;
    logic                is_valid;
    logic [KIND_W-1:0]   stored_kind;
    logic                kind_match;
  } reply_t;

  class slot_ledger;
    bit [IDX_W-1:0]  free_idx [SLOTS];
    bit [IDX_W:0]    depth;
    gen_t            gen [SLOTS];
    bit              live [SLOTS];
    bit [KIND_W-1:0] kinds [SLOTS];
    reply_t          owed [$];
    logic [63:0]     retired [$];
    int unsigned     errors;
    int unsigned     replies;

    function new();
      for (int k = 0; k < SLOTS; k++) begin
        free_idx[k] = IDX_W'(k + 1);
        gen[k]      = '0;
        live[k]     = 1'b0;
        kinds[k]    = '0;
      end
      depth   = '0;
      errors  = 0;
      replies = 0;
    endfunction

    // True when the handle names a live slot at its current generation.
    function bit current(logic [63:0] h);
      logic [31:0] idx;
      idx = h[63:32];
      if (idx == 0 || idx >= SLOTS) return 1'b0;
      return live[idx] && gen[idx] == h[31:0];
    endfunction

    function void record_request(logic [1:0] act, logic [63:0] h, logic [KIND_W-1:0] k);
      reply_t         r;
      bit [IDX_W-1:0] slot;
      r.status      = ST_STALE;
      r.new_handle  = '0;
      r.is_valid    = 1'b0;
      r.stored_kind = '0;
      r.kind_match  = 1'b0;
      case (act)
        ACT_CREATE: begin
          if (depth >= SLOTS - 1) begin
            r.status = ST_FULL;
          end else begin
            slot        = free_idx[depth];
            depth       = depth + 1'b1;
            gen[slot]   = gen[slot] + 1'b1;
            live[slot]  = 1'b1;
            kinds[slot] = k;
            r.status     = ST_OK;
            r.new_handle = {32'(slot), gen[slot]};
          end
        end
        ACT_DESTROY: begin
          if (current(h) && depth != 0) begin
            slot            = IDX_W'(h[63:32]);
            depth           = depth - 1'b1;
            free_idx[depth] = slot;
            live[slot]      = 1'b0;
            retired.push_back(h);
            if (retired.size() > 64) void'(retired.pop_front());
            r.status = ST_OK;
          end
        end
        ACT_QUERY: begin
          if (current(h)) begin
            r.status      = ST_OK;
            r.is_valid    = 1'b1;
            r.stored_kind = kinds[h[63:32]];
            r.kind_match  = kinds[h[63:32]] == k;
          end
        end
        default: ;
      endcase
      owed.push_back(r);
    endfunction

    function void note(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t ns: reply %0d, %s expected %h, got %h", $time, replies, field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (owed.size() == 0) begin
        $display("%0t ns: reply with none outstanding, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = owed.pop_front();
      replies++;
      note("status", want.status, got.status);
      note("new_handle", want.new_handle, got.new_handle);
      note("is_valid", want.is_valid, got.is_valid);
      note("stored_kind", want.stored_kind, got.stored_kind);
      note("kind_match", want.kind_match, got.kind_match);
    endfunction

    function bit pick_live(inout logic [63:0] h);
      int unsigned pool [$];
      int unsigned idx;
      for (int k = 1; k < SLOTS; k++) if (live[k]) pool.push_back(k);
      if (pool.size() == 0) return 1'b0;
      idx = pool[$urandom_range(pool.size() - 1)];
      h   = {idx[31:0], gen[idx]};
      return 1'b1;
    endfunction

    function bit pick_retired(inout logic [63:0] h);
      if (retired.size() == 0) return 1'b0;
      h = retired[$urandom_range(retired.size() - 1)];
      return 1'b1;
    endfunction
  endclass

endpackage

// ===== sim/tb_generational_handle_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Handle allocator testbench
// Drives create, destroy, query and unknown request words into the allocator
// and checks every reply word against a slot ledger kept in step with it.
// ----------------------------------------------------------------------------
module tb_generational_handle_allocator;

  import gha_pkg::*;
  import gha_ledger_pkg::*;

  // The action port is two bits wide; its fourth code is not an operation and
  // must be answered as a stale request that changes nothing.
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  // Cycles in which neither channel moves a word before the run is abandoned.
  // The longest quiet stretch of a correct run is the deliberate receiver
  // hold-off plus the idle stretches around it.
  localparam int STALL_LIMIT = 2000;

  // Mixes of request words for the random part: the first drives the stack to
  // exhaustion, the second churns near full, the third gives slots back.
  typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic [1:0]          action = '0;
  logic [63:0]         handle = '0;
  logic [KIND_W-1:0]   kind = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  logic [1:0]          status;
  logic [63:0]         new_handle;
  logic                is_valid;
  logic [KIND_W-1:0]   stored_kind;
  logic                kind_match;

  slot_ledger ledger;
  reply_t     seen;
  int         tx_idle_pct = 28;
  int         rx_idle_pct = 59;
  int         rx_hold_span = 0;
  int         stall_count = 0;

  generational_handle_allocator #(
    .SLOT_COUNT (SLOTS),
    .KIND_BITS  (KIND_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .action      (action),
    .handle      (handle),
    .kind        (kind),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .new_handle  (new_handle),
    .is_valid    (is_valid),
    .stored_kind (stored_kind),
    .kind_match  (kind_match)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Both channels are sampled at the rising edge. A request word updates the
  // ledger at once, so that the next word the sender picks already sees the
  // slot table as the block will hold it.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) ledger.record_request(action, handle, kind);
      if (rsp_valid && rsp_ready) begin
        seen.status      = status_t'(status);
        seen.new_handle  = new_handle;
        seen.is_valid    = is_valid;
        seen.stored_kind = stored_kind;
        seen.kind_match  = kind_match;
        ledger.check_reply(seen);
      end
    end
  end

  // Watchdog: any word moved on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_count = 0;
    else stall_count++;
    if (stall_count >= STALL_LIMIT) begin
      $display("tb_generational_handle_allocator: done, errors");
      $finish;
    end
  end

  // Receiver. It normally drops ready at random; when a hold-off is asked for
  // it keeps ready low through the requested span, so the pipeline backs up into
  // the request channel while the sender keeps offering words.
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold_span != 0) begin
        rsp_ready <= 1'b0;
        repeat (rx_hold_span) @(negedge clk);
        rx_hold_span = 0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [63:0] make_handle(input int unsigned idx, input gen_t g);
    return {idx[31:0], g};
  endfunction

  // Offers one request word and returns at the falling edge after it has been
  // taken. Valid is only lowered when a gap is inserted, so a word that
  // follows directly keeps valid high without a glitch.
  task automatic send_word(input logic [1:0] act, input logic [63:0] h,
                           input logic [KIND_W-1:0] k);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    action    <= act;
    handle    <= h;
    kind      <= k;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // The sender stands still until every outstanding reply has come back.
  task automatic wait_for_replies();
    req_valid <= 1'b0;
    while (ledger.owed.size() != 0) @(negedge clk);
  endtask

  // Hand-picked words after reset. The stack hands out slot 1 first and a
  // freed slot is the next one handed out again, which the handles below
  // rely on.
  task automatic run_directed();
    send_word(ACT_QUERY,   make_handle(1, 0), 8'h00);  // nothing issued yet
    send_word(ACT_DESTROY, '0, 8'hFF);                 // slot 0 is never valid
    send_word(ACT_CREATE,  '1, 8'hFF);                 // handle is ignored: 1/1
    send_word(ACT_CREATE,  '0, 8'h00);                 // 2/1
    send_word(ACT_QUERY,   make_handle(1, 1), 8'hFF);  // live, kinds agree
    send_word(ACT_QUERY,   make_handle(1, 1), 8'hFE);  // live, kinds differ
    send_word(ACT_QUERY,   make_handle(2, 1), 8'h00);  // stored kind of zero
    send_word(ACT_QUERY,   make_handle(1, 2), 8'hFF);  // generation ahead
    send_word(ACT_DESTROY, make_handle(SLOTS, 1), 8'h00);  // index past the table
    send_word(ACT_QUERY,   '1, 8'hFF);
    send_word(ACT_UNKNOWN, make_handle(1, 1), 8'hFF);  // ignored, slot stays live
    send_word(ACT_DESTROY, make_handle(1, 1), 8'h5A);
    send_word(ACT_DESTROY, make_handle(1, 1), 8'h5A);  // already retired
    send_word(ACT_QUERY,   make_handle(1, 1), 8'hFF);
    send_word(ACT_CREATE,  '0, 8'hA5);                 // slot 1 again, generation 2
    send_word(ACT_QUERY,   make_handle(1, 1), 8'hA5);  // old generation
    send_word(ACT_QUERY,   make_handle(1, 2), 8'hA5);
    send_word(ACT_CREATE,  '0, 8'h3C);                 // 3/1
    send_word(ACT_DESTROY, make_handle(2, 1), 8'h00);
    send_word(ACT_DESTROY, make_handle(1, 2), 8'h00);
    send_word(ACT_CREATE,  '0, 8'h81);                 // back to back with the push
    send_word(ACT_CREATE,  '0, 8'h7E);
    send_word(ACT_QUERY,   make_handle(1, 3), 8'h81);
  endtask

  // Random words. Most are well formed: creates, and destroys and queries of
  // handles that are live right now. The rest are stale handles (retired or
  // with a wrong generation) and noise: arbitrary handles, slot 0, indices
  // past the table and the unknown action.
  task automatic run_random(input int count, input mix_t mix);
    int                create_w;
    int                destroy_w;
    int                query_w;
    int                stale_w;
    int                roll;
    logic [1:0]        act;
    logic [63:0]       h;
    logic [KIND_W-1:0] k;
    case (mix)
      MIX_FILL: begin
        create_w = 93; destroy_w = 2; query_w = 2; stale_w = 2;
      end
      MIX_BALANCED: begin
        create_w = 35; destroy_w = 25; query_w = 20; stale_w = 10;
      end
      default: begin
        create_w = 15; destroy_w = 45; query_w = 20; stale_w = 10;
      end
    endcase
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      k    = KIND_W'($urandom);
      h    = {$urandom, $urandom};
      act  = ACT_CREATE;
      if (roll < create_w) begin
        act = ACT_CREATE;
      end else if (roll < create_w + destroy_w + query_w) begin
        // With nothing live the word falls back to a create.
        if (ledger.pick_live(h)) begin
          act = (roll < create_w + destroy_w) ? ACT_DESTROY : ACT_QUERY;
          if ($urandom_range(1)) k = ledger.kinds[h[63:32]];
        end
      end else if (roll < create_w + destroy_w + query_w + stale_w) begin
        act = $urandom_range(1) ? ACT_DESTROY : ACT_QUERY;
        if (!ledger.pick_retired(h) && ledger.pick_live(h))
          h[31:0] = h[31:0] + $urandom_range(1, 3);
      end else begin
        act = $urandom_range(1) ? ACT_DESTROY : ACT_QUERY;
        case ($urandom_range(3))
          0: ;
          1: h[63:32] = '0;
          2: h[63:32] = $urandom_range(32'hFFFF_FFFF, SLOTS);
          default: begin
            act = ACT_UNKNOWN;
            void'(ledger.pick_live(h));
          end
        endcase
      end
      send_word(act, h, k);
    end
  endtask

  initial begin
    ledger = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sender idles less than the receiver; the stack is driven to full and
    // kept there for a while.
    run_directed();
    run_random(300, MIX_FILL);
    wait_for_replies();

    // Roles swapped. The receiver starts with a long hold-off while the
    // sender carries on, so the request channel stalls behind a full pipe.
    tx_idle_pct  = 59;
    rx_idle_pct  = 28;
    rx_hold_span = 40;
    run_random(130, MIX_BALANCED);
    wait_for_replies();

    // Neither side idles; halfway through, the sender waits for every reply.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(65, MIX_DRAIN);
    wait_for_replies();
    run_random(65, MIX_DRAIN);
    wait_for_replies();

    // A last wait, to catch any stray reply.
    repeat (8) @(posedge clk);
    if (ledger.owed.size() != 0) begin
      $display("%0t ns: %0d replies never arrived", $time, ledger.owed.size());
      ledger.errors++;
    end
    if (ledger.errors == 0) begin
      $display("tb_generational_handle_allocator: done, clean");
    end else begin
      $display("tb_generational_handle_allocator: done, errors");
    end
    $finish;
  end

endmodule
